// ----- rtl/core/uer_pkg.sv -----
// Shared constants, types and helpers for the ultrasonic echo ranger core.
// Depends on nothing; imported by ultrasonic_echo_ranger_core.
package uer_pkg;

    // Width of the trigger phase counter and the echo tick counter.
    localparam int COUNT_WIDTH = 16;
    localparam int RANGE_W     = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int TPC_W       = 8;
    localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH);
    localparam int CMP_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Register reset values.
    localparam logic [7:0]  TRIG_TICKS_RST  = 8'd18;
    localparam logic [15:0] PERIOD_TICKS_RST = 16'd55296;
    localparam logic [7:0]  TICKS_PER_CM_RST = 8'd58;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_TICKS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_CM  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WB
    } t_state;

    // Clamp a quotient to the range field width.
    function automatic logic [RANGE_W-1:0] sat_range(input logic [COUNT_WIDTH-1:0] q);
        logic [COUNT_WIDTH+RANGE_W-1:0] wide;
        wide = {{RANGE_W{1'b0}}, q};
        if (wide[COUNT_WIDTH+RANGE_W-1:RANGE_W] != '0) begin
            return '1;
        end
        return wide[RANGE_W-1:0];
    endfunction

endpackage

// ----- rtl/core/ultrasonic_echo_ranger_core.sv -----
// Top level of the ultrasonic echo ranger: trigger sequencer, echo timer and
// a bit-serial restoring divider for the distance. Depends on uer_pkg.
//
// Usage: each input item is one timer tick carrying the sampled echo level.
// Every accepted item gives exactly one result item with the trigger level
// for that tick, the held range in centimeters and a new-range flag.
// Channels use valid/ready; an item moves when both are high. Configuration
// registers (trigger_ticks, period_ticks, ticks_per_cm) are written through
// i_cfg_we/i_cfg_addr/i_cfg_wdata; the user is to write them only while the
// core is idle, as the core itself does not enforce this.
// An ordinary tick, or a falling echo edge with a zero divisor, shows its
// result in the cycle after acceptance, and the next tick can be taken in
// that same cycle, so such ticks flow at one per cycle while the receiver
// takes every result. A falling echo edge runs the divider, which retires
// one quotient bit per cycle, followed by a write-back state: the next tick
// is taken at the earliest together with that result item.
// Reset (synchronous, active low) restores the register defaults, clears
// the echo state and starts the trigger in its high phase.
// When the receiver stalls, the result waits in the output register and no
// new tick is accepted until it has been taken or is being taken.
module ultrasonic_echo_ranger_core
    import uer_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_echo_level,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_trigger_out,
    output logic [RANGE_W-1:0]    o_range_cm,
    output logic                  o_range_new,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    // Configuration registers.
    logic [7:0]             r_trigger_ticks;
    logic [15:0]            r_period_ticks;
    logic [TPC_W-1:0]       r_ticks_per_cm;

    // Sequencer and echo state.
    t_state                 r_state, n_state;
    logic [COUNT_WIDTH-1:0] r_phase_count;
    logic                   r_trig_phase;
    logic                   r_echo_prev;
    logic                   r_echo_busy;
    logic [COUNT_WIDTH-1:0] r_echo_count;
    logic [RANGE_W-1:0]     r_range_hold;

    // Divider.
    logic [COUNT_WIDTH-1:0] r_quo;
    logic [TPC_W-1:0]       r_rem;
    logic [DIV_CNT_W-1:0]   r_bit_cnt;
    logic                   r_pend_trig;

    // Output register.
    logic                   r_out_valid;
    logic                   r_out_trig;
    logic [RANGE_W-1:0]     r_out_range;
    logic                   r_out_new;

    logic                   accept;
    logic                   slot_free;
    logic                   div_step;
    logic                   wb_load;
    logic [COUNT_WIDTH-1:0] phase_inc;
    logic [CMP_W-1:0]       phase_limit;
    logic                   phase_end;
    logic                   echo_rise;
    logic                   echo_fall;
    logic [COUNT_WIDTH-1:0] echo_inc;
    logic                   start_div;
    logic                   div_last;
    logic [TPC_W:0]         rem_sh;
    logic [TPC_W:0]         rem_diff;
    logic                   q_bit;

    assign slot_free = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;

    // Trigger phase sequencing for the current tick.
    always_comb begin
        phase_inc   = (r_phase_count == CNT_MAX) ? CNT_MAX : r_phase_count + 1'b1;
        phase_limit = r_trig_phase ? CMP_W'(r_trigger_ticks) : CMP_W'(r_period_ticks);
        phase_end   = (CMP_W'(phase_inc) >= phase_limit) || (phase_inc == CNT_MAX);
    end

    // Echo edge detection and the saturating tick count.
    always_comb begin
        echo_rise = i_echo_level && !r_echo_prev;
        echo_fall = !echo_rise && r_echo_busy && !i_echo_level;
        echo_inc  = (r_echo_count == CNT_MAX) ? CNT_MAX : r_echo_count + 1'b1;
        start_div = echo_fall && (r_ticks_per_cm != '0);
    end

    // One restoring division step: shift in the next dividend bit, try subtracting.
    always_comb begin
        rem_sh   = {r_rem, r_quo[COUNT_WIDTH-1]};
        rem_diff = rem_sh - {1'b0, r_ticks_per_cm};
        q_bit    = (rem_sh >= {1'b0, r_ticks_per_cm});
        div_last = (r_bit_cnt == DIV_CNT_W'(COUNT_WIDTH - 1));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && start_div) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        o_ready  = 1'b0;
        div_step = 1'b0;
        wb_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready  = slot_free;
            ST_DIV:  div_step = 1'b1;
            ST_WB:   wb_load  = slot_free;
            default: o_ready  = 1'b0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= TRIG_TICKS_RST;
            r_period_ticks  <= PERIOD_TICKS_RST;
            r_ticks_per_cm  <= TICKS_PER_CM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_wdata[7:0];
                REG_PERIOD_TICKS:  r_period_ticks  <= i_cfg_wdata[15:0];
                REG_TICKS_PER_CM:  r_ticks_per_cm  <= i_cfg_wdata[TPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state: sequencer, echo tracking, held range and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase_count <= '0;
            r_trig_phase  <= 1'b1;
            r_echo_prev   <= 1'b0;
            r_echo_busy   <= 1'b0;
            r_echo_count  <= '0;
            r_range_hold  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (phase_end) begin
                    r_trig_phase  <= !r_trig_phase;
                    r_phase_count <= '0;
                end else begin
                    r_phase_count <= phase_inc;
                end
                r_echo_prev <= i_echo_level;
                if (echo_rise) begin
                    r_echo_count <= '0;
                    r_echo_busy  <= 1'b1;
                end else if (r_echo_busy) begin
                    r_echo_count <= echo_inc;
                    if (!i_echo_level) begin
                        r_echo_busy <= 1'b0;
                    end
                end
                if (echo_fall && !start_div) begin
                    r_range_hold <= '1;
                end
            end
            if (wb_load) begin
                r_range_hold <= sat_range(r_quo);
            end
            if ((accept && !start_div) || wb_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider datapath and the output payload.
    always_ff @(posedge i_clk) begin
        if (accept && start_div) begin
            r_quo       <= echo_inc;
            r_rem       <= '0;
            r_bit_cnt   <= '0;
            r_pend_trig <= r_trig_phase;
        end else if (div_step) begin
            r_quo     <= {r_quo[COUNT_WIDTH-2:0], q_bit};
            r_rem     <= q_bit ? rem_diff[TPC_W-1:0] : rem_sh[TPC_W-1:0];
            r_bit_cnt <= r_bit_cnt + 1'b1;
        end
        if (accept && !start_div) begin
            r_out_trig  <= r_trig_phase;
            r_out_range <= echo_fall ? '1 : r_range_hold;
            r_out_new   <= echo_fall;
        end else if (wb_load) begin
            r_out_trig  <= r_pend_trig;
            r_out_range <= sat_range(r_quo);
            r_out_new   <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_trigger_out = r_out_trig;
    assign o_range_cm    = r_out_range;
    assign o_range_new   = r_out_new;

    // The core takes a tick only from the idle state.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == ST_IDLE))
        else $error("input ready outside the idle state");

    // A shown result always carries the held range.
    a_range_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_cm == r_range_hold))
        else $error("output range differs from the held range");

    // The divider only runs with a nonzero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_ticks_per_cm != '0))
        else $error("division started with a zero divisor");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_ticks_per_cm))
        else $error("partial remainder not below the divisor");

    // The divider hands over to write-back right after its last step.
    a_div_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && div_last) |=> (r_state == ST_WB))
        else $error("divider did not finish after its last step");

endmodule
